// ===== rtl/bsc_pkg.sv =====
// ----------------------------------------------------------------------------
// bsc_pkg
// shared types, codes and character mapping for the base64 stream codec
// ----------------------------------------------------------------------------
`default_nettype none

package bsc_pkg;

  // direction register codes
  localparam logic DIR_ENCODE = 1'b0;
  localparam logic DIR_DECODE = 1'b1;

  // register byte addresses
  localparam logic [1:0] ADDR_DIRECTION = 2'd0;

  localparam logic [7:0] PAD_CHAR = 8'h3d;  // '='

  // one queued burst: up to four result bytes, emitted from index 0
  typedef struct packed {
    logic [3:0][7:0] data;
    logic [1:0]      last_idx;  // index of the final result in the burst
    logic            has_data;
    logic            eom;
  } entry_t;

  // six-bit value to alphabet character
  function automatic logic [7:0] sextet_char(input logic [5:0] v);
    logic [7:0] c;
    if (v < 6'd26) begin
      c = 8'h41 + 8'(v);
    end else if (v < 6'd52) begin
      c = 8'h61 + 8'(v - 6'd26);
    end else if (v < 6'd62) begin
      c = 8'h30 + 8'(v - 6'd52);
    end else if (v == 6'd62) begin
      c = 8'h2b;
    end else begin
      c = 8'h2f;
    end
    return c;
  endfunction

  // alphabet character to {ok, six-bit value}; ok low outside the alphabet
  function automatic logic [6:0] char_sextet(input logic [7:0] c);
    logic [6:0] r;
    if (c >= 8'h41 && c <= 8'h5a) begin
      r = {1'b1, 6'(c - 8'h41)};
    end else if (c >= 8'h61 && c <= 8'h7a) begin
      r = {1'b1, 6'(c - 8'h61 + 8'd26)};
    end else if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 6'(c - 8'h30 + 8'd52)};
    end else if (c == 8'h2b) begin
      r = {1'b1, 6'd62};
    end else if (c == 8'h2f) begin
      r = {1'b1, 6'd63};
    end else begin
      r = 7'd0;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/bsc_front.sv =====
// ----------------------------------------------------------------------------
// bsc_front
// accepts input transactions, keeps the group state, builds result bursts
// ----------------------------------------------------------------------------
`default_nettype none

module bsc_front (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           direction,
  input  wire logic           cfg_clear,
  input  wire logic           in_valid,
  output      logic           in_stall,
  input  wire logic [7:0]     in_byte,
  input  wire logic           in_last,
  input  wire logic           queue_full,
  output      logic           push,
  output      bsc_pkg::entry_t entry
);

  logic [23:0] group_bits, group_bits_next;
  logic [1:0]  group_count, group_count_next;
  logic        decode_stopped, decode_stopped_next;
  logic [2:0]  n;
  logic        accept;
  logic [23:0] sh;
  logic [15:0] pair;
  logic [6:0]  dec;

  assign in_stall = queue_full;
  assign accept   = in_valid && !queue_full;
  assign push     = accept && ((n != 3'd0) || in_last);

  always_comb begin
    group_bits_next     = group_bits;
    group_count_next    = group_count;
    decode_stopped_next = decode_stopped;
    entry               = '0;
    n                   = 3'd0;
    sh                  = '0;
    pair                = '0;
    dec                 = bsc_pkg::char_sextet(in_byte);

    if (direction == bsc_pkg::DIR_ENCODE) begin
      sh = {group_bits[15:0], in_byte};
      if (group_count == 2'd2) begin
        entry.data[0]    = bsc_pkg::sextet_char(sh[23:18]);
        entry.data[1]    = bsc_pkg::sextet_char(sh[17:12]);
        entry.data[2]    = bsc_pkg::sextet_char(sh[11:6]);
        entry.data[3]    = bsc_pkg::sextet_char(sh[5:0]);
        n                = 3'd4;
        group_bits_next  = '0;
        group_count_next = 2'd0;
      end else begin
        group_bits_next  = sh;
        group_count_next = group_count + 2'd1;
        if (in_last) begin
          if (group_count == 2'd0) begin
            entry.data[0] = bsc_pkg::sextet_char(in_byte[7:2]);
            entry.data[1] = bsc_pkg::sextet_char({in_byte[1:0], 4'd0});
            entry.data[2] = bsc_pkg::PAD_CHAR;
            entry.data[3] = bsc_pkg::PAD_CHAR;
          end else begin
            pair          = {group_bits[7:0], in_byte};
            entry.data[0] = bsc_pkg::sextet_char(pair[15:10]);
            entry.data[1] = bsc_pkg::sextet_char(pair[9:4]);
            entry.data[2] = bsc_pkg::sextet_char({pair[3:0], 2'd0});
            entry.data[3] = bsc_pkg::PAD_CHAR;
          end
          n = 3'd4;
        end
      end
    end else begin
      if (!decode_stopped) begin
        if (!dec[6]) begin
          decode_stopped_next = 1'b1;
        end else begin
          sh = {group_bits[17:0], dec[5:0]};
          if (group_count == 2'd3) begin
            entry.data[0]    = sh[23:16];
            entry.data[1]    = sh[15:8];
            entry.data[2]    = sh[7:0];
            n                = 3'd3;
            group_bits_next  = '0;
            group_count_next = 2'd0;
          end else begin
            group_bits_next  = sh;
            group_count_next = group_count + 2'd1;
          end
        end
      end
      // flush a partial group: n held sextets give n-1 bytes
      if (in_last) begin
        if (group_count_next == 2'd2) begin
          entry.data[0] = group_bits_next[11:4];
          n             = 3'd1;
        end else if (group_count_next == 2'd3) begin
          entry.data[0] = group_bits_next[17:10];
          entry.data[1] = group_bits_next[9:2];
          n             = 3'd2;
        end
      end
    end

    if (n != 3'd0) begin
      entry.has_data = 1'b1;
      entry.last_idx = 2'(n - 3'd1);
    end
    if (in_last) begin
      entry.eom           = 1'b1;
      group_bits_next     = '0;
      group_count_next    = 2'd0;
      decode_stopped_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_clear) begin
      group_bits     <= '0;
      group_count    <= 2'd0;
      decode_stopped <= 1'b0;
    end else if (accept) begin
      group_bits     <= group_bits_next;
      group_count    <= group_count_next;
      decode_stopped <= decode_stopped_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/bsc_fifo.sv =====
// ----------------------------------------------------------------------------
// bsc_fifo
// short queue of result bursts between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module bsc_fifo #(
  parameter int DEPTH = 2
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire bsc_pkg::entry_t wr_data,
  input  wire logic            pop,
  output      bsc_pkg::entry_t rd_data,
  output      logic            full,
  output      logic            empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  bsc_pkg::entry_t mem [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (!full || pop))
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !empty)
    else $error("queue read while empty");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("queue count out of range");

endmodule

`default_nettype wire

// ===== rtl/bsc_back.sv =====
// ----------------------------------------------------------------------------
// bsc_back
// unrolls queued bursts into single result transactions
// ----------------------------------------------------------------------------
`default_nettype none

module bsc_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            queue_empty,
  input  wire bsc_pkg::entry_t head,
  output      logic            pop,
  output      logic            out_valid,
  input  wire logic            out_stall,
  output      logic [7:0]      out_byte,
  output      logic            has_data,
  output      logic            end_of_message
);

  bsc_pkg::entry_t cur;
  logic            cur_valid;
  logic [1:0]      idx;
  logic            adv, take, cur_done;

  assign adv      = !out_valid || !out_stall;
  assign take     = adv && cur_valid;
  assign cur_done = take && (idx == cur.last_idx);
  assign pop      = !queue_empty && (!cur_valid || cur_done);

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        cur_valid <= 1'b1;
        idx       <= 2'd0;
      end else if (cur_done) begin
        cur_valid <= 1'b0;
      end else if (take) begin
        idx <= idx + 2'd1;
      end
      if (adv) begin
        out_valid <= cur_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
    if (take) begin
      out_byte       <= cur.data[idx];
      has_data       <= cur.has_data;
      end_of_message <= cur.eom && (idx == cur.last_idx);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/base64_stream_codec.sv =====
// ----------------------------------------------------------------------------
// base64_stream_codec
// byte-serial base64 encoder and decoder with a direction register
// ----------------------------------------------------------------------------
//
//  channel  | signals                                    | flow
//  ---------+--------------------------------------------+---------------------
//  input    | in_valid, in_stall, in_byte, in_last       | one byte per transaction
//  output   | out_valid, out_stall, out_byte, has_data,  | one result per transaction
//           | end_of_message                             |
//  config   | psel, penable, pwrite, paddr, pwdata,      | direction at address 0
//           | prdata, pready                             |
//
//  an input transaction is taken every cycle while the burst queue has room;
//  the output side delivers at most one result per cycle, so encoding (four
//  characters per three bytes) is bounded by the output side and decoding
//  by the input side
//  an input transaction reaches the first result valid through the burst
//  queue, the burst register and the output register
//  rst is synchronous and clears the group state, queue and output register
//  in_stall rises only when the burst queue is full; out_stall holds the
//  output register and lets the queue fill behind it
// ----------------------------------------------------------------------------
`default_nettype none

module base64_stream_codec #(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // input channel
  input  wire logic        in_valid,
  output      logic        in_stall,
  input  wire logic [7:0]  in_byte,
  input  wire logic        in_last,
  // output channel
  output      logic        out_valid,
  input  wire logic        out_stall,
  output      logic [7:0]  out_byte,
  output      logic        has_data,
  output      logic        end_of_message,
  // configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [1:0]  paddr,
  input  wire logic [31:0] pwdata,
  output      logic [31:0] prdata,
  output      logic        pready
);

  logic            direction;
  logic            cfg_write;
  logic            cfg_clear;
  logic            push, pop;
  logic            queue_full, queue_empty;
  bsc_pkg::entry_t push_entry;
  bsc_pkg::entry_t head_entry;

  // register access: writes land in the access phase, reads are immediate
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign cfg_clear = cfg_write && (paddr == bsc_pkg::ADDR_DIRECTION);
  assign prdata    = (paddr == bsc_pkg::ADDR_DIRECTION) ? {31'd0, direction} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      direction <= bsc_pkg::DIR_ENCODE;
    end else if (cfg_clear) begin
      // writing direction also drops any partial message in the front
      direction <= pwdata[0];
    end
  end

  // front: accepts bytes, tracks the group and builds whole result bursts
  bsc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .direction  (direction),
    .cfg_clear  (cfg_clear),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_byte    (in_byte),
    .in_last    (in_last),
    .queue_full (queue_full),
    .push       (push),
    .entry      (push_entry)
  );

  // burst queue decouples the input from output stalls
  bsc_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_data (push_entry),
    .pop     (pop),
    .rd_data (head_entry),
    .full    (queue_full),
    .empty   (queue_empty)
  );

  // back: walks each burst one result per output transaction
  bsc_back u_back (
    .clk            (clk),
    .rst            (rst),
    .queue_empty    (queue_empty),
    .head           (head_entry),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .has_data       (has_data),
    .end_of_message (end_of_message)
  );

endmodule

`default_nettype wire

// ===== test/tb_base64_stream_codec.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_base64_stream_codec
// self-checking testbench for the byte-serial base64 encoder and decoder
// ----------------------------------------------------------------------------
// directed messages cover padding, flushing of partial groups, stop characters,
// end-only markers and abandoned messages, then random messages run under
// three idling mixes and a long receiver hold; every output transaction is
// compared against an in-bench model of the codec
// ----------------------------------------------------------------------------

module tb_base64_stream_codec;

  // misaligned byte address, decodes to no register
  localparam logic [1:0] ADDR_UNUSED = 2'd2;
  // cycles to let the block settle before a register write
  localparam int SETTLE_CYCLES = 4;
  localparam int LONG_HOLD_CYCLES = 80;

  typedef struct packed {
    logic [7:0] data;
    logic       has_data;
    logic       eom;
  } codec_result_t;

  // clock, reset and block ports, the bench-driven ones known from time zero
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_byte = 8'd0;
  logic        in_last = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_byte;
  logic        has_data;
  logic        end_of_message;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [1:0]  paddr = 2'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  // model state of the codec
  logic        model_dir = bsc_pkg::DIR_ENCODE;
  logic [23:0] model_bits = 24'd0;
  int          model_count = 0;
  logic        model_stopped = 1'b0;

  // results still owed by the block, oldest first
  codec_result_t expected_results[$];

  string alphabet_chars =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  int errors = 0;
  int items_sent = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  // long receiver hold, requested by a toggle and counted in the stall process
  logic hold_req = 1'b0;
  logic hold_seen = 1'b0;
  int   hold_len = 0;
  int   hold_left = 0;

  base64_stream_codec DUT (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_byte       (in_byte),
    .in_last       (in_last),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_byte      (out_byte),
    .has_data      (has_data),
    .end_of_message(end_of_message),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // codec model
  // ---------------------------------------------------------------------------

  // sextet value of a character, -1 outside the alphabet (pad included)
  function automatic int alphabet_index(input logic [7:0] c);
    for (int k = 0; k < 64; k++) begin
      if (alphabet_chars[k] == c) return k;
    end
    return -1;
  endfunction

  // append one owed result at the young end of the queue
  function automatic void owe_result(input codec_result_t r);
    expected_results.insert(expected_results.size(), r);
  endfunction

  function automatic void owe_byte(input logic [7:0] d);
    owe_result(codec_result_t'{d, 1'b1, 1'b0});
  endfunction

  function automatic void clear_group();
    model_bits = 24'd0;
    model_count = 0;
    model_stopped = 1'b0;
  endfunction

  // work out the results caused by one accepted input transaction
  function automatic void predict_item(input logic [7:0] b, input logic last);
    int            first_idx;
    int            held;
    int            sext;
    logic [23:0]   bits;
    codec_result_t tail;
    first_idx = expected_results.size();
    if (model_dir == bsc_pkg::DIR_ENCODE) begin
      model_bits = {model_bits[15:0], b};
      model_count++;
      if (model_count == 3) begin
        for (int i = 0; i < 4; i++) owe_byte(alphabet_chars[model_bits[18 - 6 * i +: 6]]);
        model_bits = 24'd0;
        model_count = 0;
      end
      // partial group: left-align, emit held+1 characters, pad the rest
      if (last && model_count != 0) begin
        held = model_count;
        bits = model_bits << (8 * (3 - held));
        for (int i = 0; i < held + 1; i++) owe_byte(alphabet_chars[bits[18 - 6 * i +: 6]]);
        for (int i = held; i < 3; i++) owe_byte(bsc_pkg::PAD_CHAR);
      end
    end else begin
      if (!model_stopped) begin
        sext = alphabet_index(b);
        if (sext < 0) begin
          // pad or foreign character ends decoding for this message
          model_stopped = 1'b1;
        end else begin
          model_bits = {model_bits[17:0], 6'(sext)};
          model_count++;
          if (model_count == 4) begin
            owe_byte(model_bits[23:16]);
            owe_byte(model_bits[15:8]);
            owe_byte(model_bits[7:0]);
            model_bits = 24'd0;
            model_count = 0;
          end
        end
      end
      // n held characters flush as n-1 bytes
      if (last && model_count > 1) begin
        held = model_count;
        bits = model_bits << (6 * (4 - held));
        for (int i = 0; i + 1 < held; i++) owe_byte(bits[16 - 8 * i +: 8]);
      end
    end
    if (last) begin
      if (expected_results.size() == first_idx) begin
        // nothing to emit: end-only marker
        owe_result(codec_result_t'{8'd0, 1'b0, 1'b1});
      end else begin
        tail = expected_results.pop_back();
        tail.eom = 1'b1;
        owe_result(tail);
      end
      clear_group();
    end
  endfunction

  // ---------------------------------------------------------------------------
  // output side: stall generation and result checking
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_req != hold_seen) begin
      // start of a long hold
      hold_seen = hold_req;
      hold_left = hold_len - 1;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= (recv_idle_pct > 0) && ($urandom_range(99) < recv_idle_pct);
    end
  end

  // compare every accepted output transaction with the oldest expectation
  always @(posedge clk) begin : check_results
    codec_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result: out_byte %h has_data %b end_of_message %b",
                 $time, out_byte, has_data, end_of_message);
        errors++;
      end else begin
        want = expected_results.pop_front();
        if (out_byte !== want.data) begin
          $display("%0t: out_byte mismatch: expected %h actual %h",
                   $time, want.data, out_byte);
          errors++;
        end
        if (has_data !== want.has_data) begin
          $display("%0t: has_data mismatch: expected %b actual %b",
                   $time, want.has_data, has_data);
          errors++;
        end
        if (end_of_message !== want.eom) begin
          $display("%0t: end_of_message mismatch: expected %b actual %b",
                   $time, want.eom, end_of_message);
          errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // input side and register port
  // ---------------------------------------------------------------------------

  // offer one byte, after random idle cycles, and wait for its transaction
  task automatic send_item(input logic [7:0] b, input logic last);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    in_last  <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_item(b, last);
    items_sent++;
  endtask

  // a whole message of characters, in_last on the final one
  task automatic send_text(input string s);
    for (int k = 0; k < s.len(); k++) send_item(s[k], k == s.len() - 1);
  endtask

  // stop offering and wait until every owed result has come
  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // idle block: drained, plus a few cycles for items that owe nothing
  task automatic settle_codec();
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // setup cycle then access cycle; the register takes the write at the end of the access cycle
  task automatic write_reg(input logic [1:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == bsc_pkg::ADDR_DIRECTION) begin
      // a direction write also drops any partial message
      model_dir = data[0];
      clear_group();
    end
  endtask

  task automatic set_direction(input logic dir);
    settle_codec();
    write_reg(bsc_pkg::ADDR_DIRECTION, {31'd0, dir});
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // one, two and three byte groups at the byte extremes
  task automatic test_encode_directed();
    set_direction(bsc_pkg::DIR_ENCODE);
    send_item(8'h00, 1'b1);
    send_item(8'hff, 1'b0);
    send_item(8'h80, 1'b1);
    send_item(8'h12, 1'b0);
    send_item(8'hfe, 1'b0);
    send_item(8'hff, 1'b1);
  endtask

  // full group, padded tail, lone character and a foreign character stop
  task automatic test_decode_directed();
    set_direction(bsc_pkg::DIR_DECODE);
    send_text("0Z9a");
    send_text("QQ=");
    send_text("A");
    // 0xff stops decoding, the rest is ignored, only the marker comes out
    send_item(8'hff, 1'b0);
    send_item(8'h00, 1'b0);
    send_item("z", 1'b1);
  endtask

  // direction write mid-message abandons it; a write to no register is ignored
  task automatic test_abandon_and_unused_write();
    set_direction(bsc_pkg::DIR_DECODE);
    send_item("T", 1'b0);
    send_item("W", 1'b0);
    set_direction(bsc_pkg::DIR_DECODE);
    settle_codec();
    write_reg(ADDR_UNUSED, {31'd0, bsc_pkg::DIR_ENCODE});
    send_text("az+/");
  endtask

  // long receiver hold while the sender keeps offering, then a mid-message pause
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_direction(bsc_pkg::DIR_ENCODE);
    hold_len <= LONG_HOLD_CYCLES;
    hold_req <= ~hold_req;
    for (int k = 0; k < 24; k++) send_item(8'($urandom_range(255)), (k % 3) == 2);
    for (int k = 0; k < 4; k++) send_item(8'($urandom_range(255)), 1'b0);
    drain_results();
    send_item(8'($urandom_range(255)), 1'b0);
    send_item(8'($urandom_range(255)), 1'b1);
  endtask

  task automatic send_random_encode();
    int len;
    logic [7:0] b;
    len = ($urandom_range(5) == 0) ? $urandom_range(12, 1) : $urandom_range(5, 1);
    for (int k = 0; k < len; k++) begin
      case ($urandom_range(9))
        0:       b = 8'h00;
        1:       b = 8'hff;
        default: b = 8'($urandom_range(255));
      endcase
      send_item(b, k == len - 1);
    end
  endtask

  // mostly well-formed base64, some padded, some noise or broken
  task automatic send_random_decode();
    int len;
    int kind;
    int pad;
    int bad_pos;
    logic [7:0] c;
    len = $urandom_range(1) ? 4 * $urandom_range(3, 1) : $urandom_range(9, 1);
    kind = $urandom_range(9);
    pad = (kind == 6) ? 1 : 2;
    bad_pos = $urandom_range(len - 1);
    for (int k = 0; k < len; k++) begin
      c = alphabet_chars[$urandom_range(63)];
      if (kind == 8) begin
        c = 8'($urandom_range(255));
      end else if (kind == 9 && k == bad_pos) begin
        c = 8'($urandom_range(255));
      end else if ((kind == 6 || kind == 7) && len > pad && k >= len - pad) begin
        c = bsc_pkg::PAD_CHAR;
      end
      send_item(c, k == len - 1);
    end
  endtask

  // random messages under one idling mix, direction changed now and then
  task automatic test_random(input int n_items, input int send_pct, input int recv_pct);
    int start;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    start = items_sent;
    while (items_sent - start < n_items) begin
      if ($urandom_range(5) == 0) begin
        set_direction($urandom_range(1) ? bsc_pkg::DIR_DECODE : bsc_pkg::DIR_ENCODE);
      end
      if (model_dir == bsc_pkg::DIR_ENCODE) send_random_encode();
      else send_random_decode();
    end
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_encode_directed();
    test_decode_directed();
    test_abandon_and_unused_write();
    test_backpressure();
    test_random(150, 34, 52);
    test_random(150, 52, 34);
    test_random(150, 0, 0);

    drain_results();
    repeat (2 * SETTLE_CYCLES) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5000000;
    $display("simulation failed");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/bsc_pkg.sv
rtl/bsc_front.sv
rtl/bsc_fifo.sv
rtl/bsc_back.sv
rtl/base64_stream_codec.sv
test/tb_base64_stream_codec.sv
